### sv/bwah_pkg.sv
package bwah_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_BINS_DEF   = 128;
  localparam int COUNT_BITS_DEF = 32;

  // Fixed field widths
  localparam int COORD_W   = 24;
  localparam int OP_W      = 2;
  localparam int SEL_W     = 7;
  localparam int IDX_W     = 7;
  localparam int OUT_CNT_W = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_ADD        = 2'd0,
    OP_READ       = 2'd1,
    OP_READ_CLEAR = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN = 3'd0,
    REG_X_MAX = 3'd1,
    REG_Y_MIN = 3'd2,
    REG_Y_MAX = 3'd3,
    REG_Z_MIN = 3'd4,
    REG_Z_MAX = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_READ,
    ST_UPDATE
  } state_t;

endpackage

### sv/bwah_ram.sv
module bwah_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/box_windowed_axis_histogram_top.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+--------------------------------------------
// in_      | input     | in_valid / in_stall  | opcode, pos_x, pos_y, pos_z, bin_select
// out_     | output    | out_valid / out_stall| inside_res, bin_index, bin_count
// cfg_     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data (box bounds, 0..5)
//
// An add passes through the check, multiply, divide, read and update states; the
// bin index comes from a restoring divider that produces one quotient bit per
// cycle. Reads and clears of a bin in range pass through check, read and update;
// misses, reads beyond the last bin and the unused opcode go from check to update.
// After reset a clearing pass writes zero to every bin, with in_stall high
// throughout; configuration writes are taken during it.
// A finished result waits in the output register under out_stall while the
// next transfer is already accepted and worked on.
module box_windowed_axis_histogram_top #(
  parameter int NUM_BINS   = bwah_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS = bwah_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample / command channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bwah_pkg::OP_W-1:0]           in_opcode,
  input  logic signed [bwah_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [bwah_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [bwah_pkg::COORD_W-1:0] in_pos_z,
  input  logic [bwah_pkg::SEL_W-1:0]          in_bin_select,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_inside_res,
  output logic [bwah_pkg::IDX_W-1:0]          out_bin_index,
  output logic [bwah_pkg::OUT_CNT_W-1:0]      out_bin_count,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bwah_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bwah_pkg::COORD_W-1:0]        cfg_data
);

  import bwah_pkg::*;

  localparam int ADDR_W = $clog2(NUM_BINS);
  localparam int PROD_W = COORD_W + ADDR_W;
  localparam int STEP_W = $clog2(ADDR_W + 1);
  localparam logic [ADDR_W-1:0] LAST_BIN  = ADDR_W'(NUM_BINS - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ADDR_W - 1);

  state_t state_r, state_nxt;

  // Box bounds
  logic signed [COORD_W-1:0] x_min_r, x_max_r, y_min_r, y_max_r, z_min_r, z_max_r;

  // Captured command
  logic [OP_W-1:0]           op_r;
  logic signed [COORD_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [SEL_W-1:0]          sel_r;

  // Divider
  logic                      hit_r;
  logic [COORD_W-1:0]        diff_r;
  logic [COORD_W-1:0]        range_r;
  logic [COORD_W-1:0]        rem_r;
  logic [ADDR_W-1:0]         quo_r;   // dividend bits out at the top, quotient in at the bottom
  logic [STEP_W-1:0]         step_r;
  logic [ADDR_W-1:0]         addr_r;
  logic [ADDR_W-1:0]         clr_addr_r;

  // Output register
  logic                      out_valid_r;
  logic                      out_inside_r;
  logic [IDX_W-1:0]          out_index_r;
  logic [OUT_CNT_W-1:0]      out_count_r;

  // Combinational datapath
  logic                      inside_c;
  logic                      sel_ok_c;
  logic [COORD_W:0]          diff_c;
  logic [COORD_W:0]          range_c;
  logic [PROD_W-1:0]         prod_c;
  logic [COORD_W:0]          trial_c;
  logic [COORD_W:0]          sub_c;
  logic                      ge_c;
  logic [ADDR_W-1:0]         bin_q_c;
  logic [ADDR_W-1:0]         bin_addr_c;
  logic [COUNT_BITS-1:0]     cnt_inc_c;
  logic [COUNT_BITS-1:0]     res_count_c;
  logic                      out_free;

  // Control to the bin store
  logic                      out_load;
  logic                      ram_we;
  logic [ADDR_W-1:0]         ram_wr_addr;
  logic [COUNT_BITS-1:0]     ram_wr_data;
  logic                      ram_rd_en;
  logic [COUNT_BITS-1:0]     ram_rd_data;

  assign cfg_ready = 1'b1;

  // Strict box test on all three axes
  assign inside_c = (pos_x_r > x_min_r) && (pos_x_r < x_max_r) &&
                    (pos_y_r > y_min_r) && (pos_y_r < y_max_r) &&
                    (pos_z_r > z_min_r) && (pos_z_r < z_max_r);
  assign sel_ok_c = (32'(sel_r) < 32'(NUM_BINS));

  // Inside the box both differences are positive and below 2^24
  assign diff_c  = {pos_z_r[COORD_W-1], pos_z_r} - {z_min_r[COORD_W-1], z_min_r};
  assign range_c = {z_max_r[COORD_W-1], z_max_r} - {z_min_r[COORD_W-1], z_min_r};
  assign prod_c  = PROD_W'(diff_r) * PROD_W'(NUM_BINS);

  // One restoring step: bring down the next dividend bit, try to subtract
  assign trial_c = {rem_r, quo_r[ADDR_W-1]};
  assign ge_c    = (trial_c >= {1'b0, range_r});
  assign sub_c   = trial_c - {1'b0, range_r};

  assign bin_q_c    = (quo_r > LAST_BIN) ? LAST_BIN : quo_r;
  assign bin_addr_c = (op_r == OP_ADD) ? bin_q_c : ADDR_W'(sel_r);

  // Saturating increment
  assign cnt_inc_c = (ram_rd_data == {COUNT_BITS{1'b1}}) ? ram_rd_data
                                                          : ram_rd_data + COUNT_BITS'(1);

  always_comb begin
    if (!hit_r) begin
      res_count_c = '0;
    end else if (op_r == OP_ADD) begin
      res_count_c = cnt_inc_c;
    end else begin
      res_count_c = ram_rd_data;
    end
  end

  // Output register accepts a new result once the old one leaves
  assign out_free = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_BIN) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (op_r == OP_ADD && inside_c) begin
          state_nxt = ST_MUL;
        end else if ((op_r == OP_READ || op_r == OP_READ_CLEAR) && sel_ok_c) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (step_r == LAST_STEP) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall    = 1'b1;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_wr_addr = addr_r;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_wr_addr = clr_addr_r;
      end
      ST_IDLE: in_stall = 1'b0;
      ST_READ: ram_rd_en = 1'b1;
      ST_UPDATE: begin
        out_load    = out_free;
        // write back the increment or the clear; a plain read leaves the bin
        ram_we      = out_free && hit_r && (op_r != OP_READ);
        ram_wr_data = (op_r == OP_ADD) ? cnt_inc_c : '0;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      x_min_r     <= '0;
      x_max_r     <= '0;
      y_min_r     <= '0;
      y_max_r     <= '0;
      z_min_r     <= '0;
      z_max_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (state_r == ST_MUL) begin
        step_r <= '0;
      end else if (state_r == ST_DIV) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_X_MIN: x_min_r <= cfg_data;
          REG_X_MAX: x_max_r <= cfg_data;
          REG_Y_MIN: y_min_r <= cfg_data;
          REG_Y_MAX: y_max_r <= cfg_data;
          REG_Z_MIN: z_min_r <= cfg_data;
          REG_Z_MAX: z_max_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      op_r    <= in_opcode;
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      pos_z_r <= in_pos_z;
      sel_r   <= in_bin_select;
    end
    if (state_r == ST_CHECK) begin
      hit_r   <= (op_r == OP_ADD) ? inside_c
                                  : ((op_r == OP_READ || op_r == OP_READ_CLEAR) && sel_ok_c);
      diff_r  <= diff_c[COORD_W-1:0];
      range_r <= range_c[COORD_W-1:0];
    end
    if (state_r == ST_MUL) begin
      // the upper part is below the range since the quotient fits ADDR_W bits
      rem_r <= prod_c[PROD_W-1 -: COORD_W];
      quo_r <= prod_c[ADDR_W-1:0];
    end
    if (state_r == ST_DIV) begin
      rem_r <= ge_c ? sub_c[COORD_W-1:0] : trial_c[COORD_W-1:0];
      quo_r <= (quo_r << 1) | ADDR_W'(ge_c);
    end
    if (state_r == ST_READ) begin
      addr_r <= bin_addr_c;
    end
    if (out_load) begin
      out_inside_r <= hit_r && (op_r == OP_ADD);
      out_count_r  <= OUT_CNT_W'(res_count_c);
      if (op_r == OP_ADD) begin
        out_index_r <= hit_r ? IDX_W'(addr_r) : '0;
      end else if (op_r == OP_READ || op_r == OP_READ_CLEAR) begin
        out_index_r <= IDX_W'(sel_r);
      end else begin
        out_index_r <= '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_bin_index  = out_index_r;
  assign out_bin_count  = out_count_r;

  bwah_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (bin_addr_c),
    .rd_data (ram_rd_data)
  );

endmodule

### sv/bwah_checker.sv
module bwah_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_inside_res,
  input logic [bwah_pkg::IDX_W-1:0]     out_bin_index,
  input logic [bwah_pkg::OUT_CNT_W-1:0] out_bin_count
);

  import bwah_pkg::*;

  // The clearing pass holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken before bin clearing pass");

  // One command in flight: a transfer closes the input for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transfer taken while a command is in flight");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      ($stable(out_inside_res) && $stable(out_bin_index) && $stable(out_bin_count)))
    else $error("result payload changed under stall");

endmodule

bind box_windowed_axis_histogram_top bwah_checker u_bwah_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_inside_res (out_inside_res),
  .out_bin_index  (out_bin_index),
  .out_bin_count  (out_bin_count)
);
